/* design/osl_pkg.sv */
// Shared types, widths and codes for the object slot table.
// Used by the channel interfaces and by every module of the block.
package osl_pkg;

    // Table size and derived widths
    localparam int SLOTS   = 256;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int SIDX_W  = 8;
    localparam int RES_W   = 8;
    localparam int CMP_W   = (CNT_W > SIDX_W) ? CNT_W : SIDX_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_IN_USE = 2'd3;

    // Id written into deleted slots
    localparam logic [KEY_W-1:0] KEY_NONE = '1;

    // One slot of the table
    typedef struct packed {
        logic             committed;
        logic             deleted;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

    // Classified command, front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              scan;
        logic [KEY_W-1:0]  key;
        logic [SIDX_W-1:0] idx;
    } cmd_t;

    // Back-end status seen at the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] used_count;
    } stat_t;

endpackage

/* design/osl_req_if.sv */
// Request channel of the object slot table: valid/ready plus one command beat.
// Depends on osl_pkg for field widths.
interface osl_req_if;
    import osl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] object_key;
    logic [SIDX_W-1:0]       slot_index;

    modport source (output valid, output op, output object_key, output slot_index,
                    input ready);
    modport sink   (input valid, input op, input object_key, input slot_index,
                    output ready);
endinterface

/* design/osl_rsp_if.sv */
// Response channel of the object slot table: valid/ready plus one result beat.
// Depends on osl_pkg for field widths.
interface osl_rsp_if;
    import osl_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [RES_W-1:0]  result_slot;

    modport source (output valid, output status, output result_slot, input ready);
    modport sink   (input valid, input status, input result_slot, output ready);
endinterface

/* design/object_slot_table.sv */
// Object slot table: first-fit slot allocation with lookup by object id.
// Top level; depends on osl_pkg, osl_req_if, osl_rsp_if, osl_front, osl_back.
//
// Usage
//   req carries one command beat (op, object_key, slot_index); rsp returns one
//   beat (status, result_slot) for every command, in order.
//   A two-entry queue sits behind req, so commands are taken while the engine
//   works and while a finished result waits on rsp.
//   Commands run one at a time. Allocate, find and delete walk the used slots
//   through the single read port of the slot memory, one slot a cycle, and
//   stop early on the first hit for allocate and find.
//   The engine starts the next command only once the result register is
//   empty; a stalled rsp therefore holds back the engine and, once the
//   queue fills, req.ready.
//   Reset clears the used count, queue and handshake state; slot contents
//   are only read below the used count and need no clearing.
module object_slot_table (
    input  logic      clk,
    input  logic      rst_n,
    osl_req_if.sink   req,
    osl_rsp_if.source rsp
);
    import osl_pkg::*;

    cmd_t  q_cmd;
    logic  q_vld;
    logic  q_pop;
    stat_t stat;

    osl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q_cmd (q_cmd),
        .q_vld (q_vld),
        .q_pop (q_pop)
    );

    osl_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_cmd (q_cmd),
        .q_vld (q_vld),
        .q_pop (q_pop),
        .rsp   (rsp),
        .stat  (stat)
    );

`ifndef ASSERT_OFF
    // a waiting result means the engine has stopped
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !stat.busy)
        else $error("engine busy while a result is pending");

    // used count never runs past the table
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used_count <= CNT_W'(SLOTS))
        else $error("used count beyond table size");

    // full only once every slot has been handed out
    a_full_used: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_FULL)) |-> (stat.used_count == CNT_W'(SLOTS)))
        else $error("full reported with free slots");

    // failed commands carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.result_slot == '0))
        else $error("non-zero slot on failed command");
`endif

endmodule

/* design/osl_front.sv */
// Front end: takes request beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on osl_pkg and osl_req_if.
module osl_front (
    input  logic            clk,
    input  logic            rst_n,
    osl_req_if.sink         req,
    output osl_pkg::cmd_t   q_cmd,
    output logic            q_vld,
    input  logic            q_pop
);
    import osl_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       cmd_in;

    // Classify the incoming beat
    always_comb
    begin
        cmd_in.op   = req.op;
        cmd_in.scan = (req.op != OP_COMMIT);
        cmd_in.key  = req.object_key;
        cmd_in.idx  = req.slot_index;
    end

    assign req.ready = (cnt_reg != Q_FULL);
    assign push      = req.valid && req.ready;
    assign q_vld     = (cnt_reg != 2'd0);
    assign q_cmd     = q_mem_reg[rd_ptr_reg];

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* design/osl_back.sv */
// Back end: owns the slot memory and the used count, scans the table one
// entry a cycle and holds the result beat. Depends on osl_pkg and osl_rsp_if.
module osl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  osl_pkg::cmd_t   q_cmd,
    input  logic            q_vld,
    output logic            q_pop,
    osl_rsp_if.source       rsp,
    output osl_pkg::stat_t  stat
);
    import osl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_CMT    = 2'd2;
    localparam logic [1:0] S_CMT_WR = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic             eval_vld_reg;
    logic             eval_vld_next;
    logic [IDX_W-1:0] eval_idx_reg;
    logic [IDX_W-1:0] eval_idx_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic             res_vld_reg;
    logic [ST_W-1:0]  res_status_reg;
    logic [RES_W-1:0] res_slot_reg;

    slot_entry_t      slot_mem [SLOTS];
    slot_entry_t      rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t      wr_data;

    logic             issue;
    logic             hit;
    logic             fin;
    logic [ST_W-1:0]  fin_status;
    logic [RES_W-1:0] fin_slot;
    logic             cmt_out;

    assign issue   = (scan_reg < used_reg);
    assign cmt_out = (CMP_W'(cmd_reg.idx) >= CMP_W'(used_reg));

    // Sequencer: scan, commit and result selection
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        scan_next     = scan_reg;
        eval_vld_next = 1'b0;
        eval_idx_next = eval_idx_reg;
        used_next     = used_reg;
        q_pop         = 1'b0;
        hit           = 1'b0;
        fin           = 1'b0;
        fin_status    = ST_OK;
        fin_slot      = '0;
        rd_en         = 1'b0;
        rd_addr       = scan_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = eval_idx_reg;
        wr_data       = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // next command only once the result register is free
                if (q_vld && !res_vld_reg)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    scan_next  = '0;
                    state_next = q_cmd.scan ? S_SCAN : S_CMT;
                end
            end

            S_SCAN:
            begin
                // evaluate the entry read last cycle
                if (eval_vld_reg)
                begin
                    unique case (cmd_reg.op)
                        OP_ALLOC:
                        begin
                            if (rd_data_reg.deleted)
                            begin
                                hit               = 1'b1;
                                fin               = 1'b1;
                                fin_slot          = RES_W'(eval_idx_reg);
                                wr_en             = 1'b1;
                                wr_data.committed = 1'b0;
                                wr_data.deleted   = 1'b0;
                                wr_data.key       = cmd_reg.key;
                            end
                        end
                        OP_FIND:
                        begin
                            if (!rd_data_reg.deleted && (rd_data_reg.key == cmd_reg.key))
                            begin
                                hit      = 1'b1;
                                fin      = 1'b1;
                                fin_slot = RES_W'(eval_idx_reg);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (rd_data_reg.key == cmd_reg.key)
                            begin
                                wr_en           = 1'b1;
                                wr_data.deleted = 1'b1;
                                wr_data.key     = KEY_NONE;
                            end
                        end
                        OP_COMMIT:
                        begin
                        end
                    endcase
                end

                if (!hit)
                begin
                    if (issue)
                    begin
                        // read the next used entry
                        rd_en         = 1'b1;
                        scan_next     = scan_reg + 1'b1;
                        eval_vld_next = 1'b1;
                        eval_idx_next = scan_reg[IDX_W-1:0];
                    end
                    else if (!eval_vld_reg)
                    begin
                        // whole table seen
                        fin = 1'b1;
                        unique case (cmd_reg.op)
                            OP_ALLOC:
                            begin
                                if (used_reg == CNT_W'(SLOTS))
                                begin
                                    fin_status = ST_FULL;
                                end
                                else
                                begin
                                    wr_en             = 1'b1;
                                    wr_addr           = used_reg[IDX_W-1:0];
                                    wr_data.committed = 1'b0;
                                    wr_data.deleted   = 1'b0;
                                    wr_data.key       = cmd_reg.key;
                                    used_next         = used_reg + 1'b1;
                                    fin_slot          = RES_W'(used_reg);
                                end
                            end
                            OP_FIND:
                            begin
                                fin_status = ST_NOT_FOUND;
                            end
                            OP_DELETE, OP_COMMIT:
                            begin
                                fin_status = ST_OK;
                            end
                        endcase
                    end
                end

                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end

            S_CMT:
            begin
                if (cmt_out)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_IN_USE;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(cmd_reg.idx);
                    state_next = S_CMT_WR;
                end
            end

            S_CMT_WR:
            begin
                // write back with the committed mark set
                wr_en             = 1'b1;
                wr_addr           = IDX_W'(cmd_reg.idx);
                wr_data.committed = 1'b1;
                fin               = 1'b1;
                state_next        = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_reg     <= '0;
            eval_vld_reg <= 1'b0;
            used_reg     <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            eval_vld_reg <= eval_vld_next;
            used_reg     <= used_next;
            if (fin)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        eval_idx_reg <= eval_idx_next;
        if (fin)
        begin
            res_status_reg <= fin_status;
            res_slot_reg   <= fin_slot;
        end
    end

    // Slot memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rsp.valid       = res_vld_reg;
    assign rsp.status      = res_status_reg;
    assign rsp.result_slot = res_slot_reg;

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.used_count = used_reg;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for object_slot_table: directed table, then random churn.
// Depends on osl_pkg, osl_req_if, osl_rsp_if and the object_slot_table RTL.
module tb_top;
    import osl_pkg::*;

    // One result beat as the table should answer it
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [RES_W-1:0] slot;
    } slot_answer_t;

    // One row of the directed stimulus; typed rows carry their answer
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [SIDX_W-1:0] idx;
        bit                typed;
        logic [ST_W-1:0]   status;
        logic [RES_W-1:0]  slot;
    } table_row_t;

    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 1300;

    logic clk;
    logic rst_n;

    osl_req_if req ();
    osl_rsp_if rsp ();

    object_slot_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Mirror of the slot table
    bit               tbl_deleted   [SLOTS];
    logic [KEY_W-1:0] tbl_key       [SLOTS];
    bit               tbl_committed [SLOTS];
    int               tbl_used;

    slot_answer_t     expected_answers [$];
    table_row_t       directed_rows [$];
    logic [KEY_W-1:0] key_pool [12];
    int               mismatch_count;
    int               burst_left;
    bit               long_hold_req;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one command to the mirror and return the answer it gives
    function automatic slot_answer_t apply_slot_op(logic [OP_W-1:0] op,
                                                   logic [KEY_W-1:0] key,
                                                   logic [SIDX_W-1:0] idx);
        slot_answer_t ans;
        int           i;
        bit           hit;
        ans.status = ST_OK;
        ans.slot   = '0;
        hit        = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                i = 0;
                while (i < tbl_used && !tbl_deleted[i])
                    i++;
                if (i == tbl_used && tbl_used >= SLOTS)
                    ans.status = ST_FULL;
                else
                begin
                    if (i == tbl_used)
                        tbl_used++;
                    tbl_deleted[i]   = 1'b0;
                    tbl_key[i]       = key;
                    tbl_committed[i] = 1'b0;
                    ans.slot         = RES_W'(i);
                end
            end
            OP_COMMIT:
            begin
                if (int'(idx) >= tbl_used)
                    ans.status = ST_NOT_IN_USE;
                else
                    tbl_committed[idx] = 1'b1;
            end
            OP_FIND:
            begin
                for (i = 0; i < tbl_used && !hit; i++)
                begin
                    if (!tbl_deleted[i] && tbl_key[i] == key)
                    begin
                        hit      = 1'b1;
                        ans.slot = RES_W'(i);
                    end
                end
                if (!hit)
                    ans.status = ST_NOT_FOUND;
            end
            default:
            begin
                // every match goes, live or already deleted
                for (i = 0; i < tbl_used; i++)
                begin
                    if (tbl_key[i] == key)
                    begin
                        tbl_deleted[i] = 1'b1;
                        tbl_key[i]     = KEY_NONE;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [SIDX_W-1:0] idx, bit typed,
                           logic [ST_W-1:0] status, logic [RES_W-1:0] slot);
        table_row_t row;
        row.op     = op;
        row.key    = key;
        row.idx    = idx;
        row.typed  = typed;
        row.status = status;
        row.slot   = slot;
        directed_rows.push_back(row);
    endtask

    // Offer one request beat and record its answer once accepted
    task automatic offer_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [SIDX_W-1:0] idx, bit typed,
                              logic [ST_W-1:0] status, logic [RES_W-1:0] slot);
        slot_answer_t ans;
        @(negedge clk);
        req.valid      <= 1'b1;
        req.op         <= op;
        req.object_key <= key;
        req.slot_index <= idx;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        ans = apply_slot_op(op, key, idx);
        if (typed)
        begin
            ans.status = status;
            ans.slot   = slot;
        end
        expected_answers.push_back(ans);
    endtask

    // Drop valid and hold the sender back; n = 0 does nothing
    task automatic hold_off_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Bursts of random length, random gaps between them
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            hold_off_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Stop sending until every outstanding beat has come back
    task automatic wait_drained();
        hold_off_sender(1);
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, 11)];
    endfunction

    // One random command; weights in percent for alloc, find, commit
    task automatic offer_random(int w_alloc, int w_find, int w_commit);
        int                r;
        logic [OP_W-1:0]   op;
        logic [SIDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < w_alloc)
            op = OP_ALLOC;
        else if (r < w_alloc + w_find)
            op = OP_FIND;
        else if (r < w_alloc + w_find + w_commit)
            op = OP_COMMIT;
        else
            op = OP_DELETE;
        idx = SIDX_W'($urandom_range(0, 255));
        if (op == OP_COMMIT && tbl_used > 0 && $urandom_range(0, 9) < 7)
            idx = SIDX_W'($urandom_range(0, tbl_used - 1));
        offer_item(op, pick_key(), idx, 1'b0, ST_OK, '0);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        slot_answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d slot %0d",
                       rsp.status, rsp.result_slot);
                mismatch_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.result_slot !== want.slot)
                begin
                    $error("result_slot mismatch: expected %0d, got %0d",
                           want.slot, rsp.result_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin : rsp_pattern
        int run_left;
        int mode;
        int hold_left;
        run_left  = 0;
        mode      = 0;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 60);
                end
                run_left--;
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= 1'($urandom_range(0, 1));
                    2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp.ready <= ((run_left % 8) < 5);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int k;
        int sent;
        int fill_extra;
        bit hold_done;
        bit pause_done;

        mismatch_count = 0;
        burst_left     = 0;
        long_hold_req  = 1'b0;
        tbl_used       = 0;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        sent           = 0;

        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.op         = OP_ALLOC;
        req.object_key = '0;
        req.slot_index = '0;

        key_pool[0] = KEY_NONE;
        key_pool[1] = 32'h0000_0000;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        for (k = 4; k < 12; k++)
            key_pool[k] = $urandom;

        // empty table, then extremes of the id, reuse and deletion by -1
        add_row(OP_FIND,   32'h0000_0000, 8'h00, 1, ST_NOT_FOUND,  8'd0);
        add_row(OP_COMMIT, 32'hFFFF_FFFF, 8'h00, 1, ST_NOT_IN_USE, 8'd0);
        add_row(OP_DELETE, KEY_NONE,      8'hFF, 1, ST_OK,         8'd0);
        add_row(OP_ALLOC,  32'h7FFF_FFFF, 8'hFF, 1, ST_OK,         8'd0);
        add_row(OP_ALLOC,  32'h8000_0000, 8'h00, 1, ST_OK,         8'd1);
        add_row(OP_ALLOC,  KEY_NONE,      8'hAA, 1, ST_OK,         8'd2);
        add_row(OP_ALLOC,  32'h0000_0000, 8'h55, 1, ST_OK,         8'd3);
        add_row(OP_COMMIT, 32'h0000_0000, 8'd3,  1, ST_OK,         8'd0);
        add_row(OP_COMMIT, 32'h0000_0000, 8'd4,  1, ST_NOT_IN_USE, 8'd0);
        add_row(OP_COMMIT, 32'h0000_0000, 8'hFF, 1, ST_NOT_IN_USE, 8'd0);
        add_row(OP_FIND,   32'h8000_0000, 8'h00, 1, ST_OK,         8'd1);
        add_row(OP_FIND,   32'h1234_5678, 8'h00, 1, ST_NOT_FOUND,  8'd0);
        add_row(OP_DELETE, 32'h8000_0000, 8'h00, 1, ST_OK,         8'd0);
        add_row(OP_FIND,   KEY_NONE,      8'h00, 1, ST_OK,         8'd2);
        // deleted slot below the count is still in range for commit
        add_row(OP_COMMIT, 32'h0000_0000, 8'd1,  1, ST_OK,         8'd0);
        add_row(OP_DELETE, KEY_NONE,      8'h00, 1, ST_OK,         8'd0);
        add_row(OP_FIND,   KEY_NONE,      8'h00, 1, ST_NOT_FOUND,  8'd0);
        add_row(OP_ALLOC,  32'd5,         8'h00, 1, ST_OK,         8'd1);
        add_row(OP_ALLOC,  32'd6,         8'h00, 1, ST_OK,         8'd2);
        add_row(OP_ALLOC,  32'd7,         8'h00, 1, ST_OK,         8'd4);
        add_row(OP_FIND,   32'd7,         8'h00, 1, ST_OK,         8'd4);
        add_row(OP_DELETE, 32'h5555_5555, 8'h00, 1, ST_OK,         8'd0);
        add_row(OP_ALLOC,  32'd5,         8'h00, 0, ST_OK,         8'd0);
        add_row(OP_FIND,   32'd5,         8'h00, 0, ST_OK,         8'd0);

        // reset
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            offer_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].idx,
                       directed_rows[r].typed, directed_rows[r].status,
                       directed_rows[r].slot);
            pace_sender();
        end
        wait_drained();

        // growth: the table fills slowly under a mixed load
        repeat (250)
        begin
            offer_random(45, 20, 15);
            pace_sender();
            sent++;
        end
        wait_drained();

        // fill to the last slot, then run into the full table
        fill_extra = 0;
        while (tbl_used < SLOTS || fill_extra < 12)
        begin
            if (tbl_used >= SLOTS)
                fill_extra++;
            offer_item(OP_ALLOC, pick_key(), SIDX_W'($urandom), 1'b0, ST_OK, '0);
            pace_sender();
            sent++;
        end

        // churn on the full table
        while (sent < RANDOM_ITEMS)
        begin
            if (!hold_done && sent > 700)
            begin
                // receiver holds off while the sender keeps pushing
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                repeat (20)
                begin
                    offer_random(35, 25, 15);
                    sent++;
                end
            end
            else if (!pause_done && sent > 1000)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                // alloc burst to drain the free slots and hit full again
                repeat ($urandom_range(4, 20))
                begin
                    offer_item(OP_ALLOC, pick_key(), SIDX_W'($urandom), 1'b0, ST_OK, '0);
                    pace_sender();
                    sent++;
                end
            end
            else
            begin
                offer_random(35, 25, 15);
                pace_sender();
                sent++;
            end
        end

        // let the last beats come back and the engine go quiet
        wait_drained();
        repeat (SLOTS + 16)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* object_slot_table.f */
design/osl_pkg.sv
design/osl_req_if.sv
design/osl_rsp_if.sv
design/osl_front.sv
design/osl_back.sv
design/object_slot_table.sv
sim/tb_top.sv
